>>> hdl/acs_pkg.sv
// shared constants, register and mode codes, and helpers of the cardinality sketch
package acs_pkg;

  // fixed field widths
  localparam int HASH_W   = 64;
  localparam int RANK_W   = 7;
  localparam int SUM_W    = 23;
  localparam int EMPTY_W  = 17;
  localparam int BIDX_W   = 16;
  localparam int KBITS_W  = 5;
  localparam int MODE_W   = 2;
  localparam int CFG_IDX_W = 1;

  // default store size
  localparam int MAX_INDEX_BITS_DEF = 16;

  // counter limits and reset values
  localparam logic [SUM_W-1:0]   RANK_MAX    = '1;
  localparam logic [EMPTY_W-1:0] EMPTY_MAX   = '1;
  localparam logic [EMPTY_W-1:0] EMPTY_RESET = 17'd1024;
  localparam logic [KBITS_W-1:0] KBITS_RESET = 5'd10;
  localparam logic [RANK_W-1:0]  MERGE_CAP   = 7'd64;
  localparam logic [RANK_W-1:0]  HL_32       = 7'd32;
  localparam logic [RANK_W-1:0]  HL_64       = 7'd64;

  // input modes
  localparam logic [MODE_W-1:0] MODE_OFFER = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MERGE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HASH_WIDTH = 1'd1;

  typedef logic [RANK_W-1:0] rank_t;

  // trailing zero count of a 64-bit word, 64 for an all-zero word
  function automatic rank_t trail_zeros(input logic [HASH_W-1:0] x);
    logic [HASH_W-1:0] v;
    rank_t             n;
    v = x;
    n = '0;
    if (x == '0) begin
      n = 7'd64;
    end else begin
      if (v[31:0] == '0) begin
        n = n + 7'd32;
        v = v >> 32;
      end
      if (v[15:0] == '0) begin
        n = n + 7'd16;
        v = v >> 16;
      end
      if (v[7:0] == '0) begin
        n = n + 7'd8;
        v = v >> 8;
      end
      if (v[3:0] == '0) begin
        n = n + 7'd4;
        v = v >> 4;
      end
      if (v[1:0] == '0) begin
        n = n + 7'd2;
        v = v >> 2;
      end
      if (v[0] == 1'b0) begin
        n = n + 7'd1;
      end
    end
    return n;
  endfunction

endpackage

>>> hdl/adaptive_cardinality_sketch.sv
// LogLog bucket sketch: two-port bucket memory with read-modify-write, forwarding and clear walk
// An offer or merge word goes through the update stage and then the output register.
// Throughput: one word per cycle while in_stall is low; back-to-back hits on one bucket are
// forwarded, not stalled. Clear: walks the whole bucket memory, then its result word shows.
// Reset (rst_n low, synchronous): counters and registers take their reset values, then a
// clearing pass zeroes the whole bucket memory while in_stall stays high.
module adaptive_cardinality_sketch #(
  parameter int MAX_INDEX_BITS = acs_pkg::MAX_INDEX_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [acs_pkg::MODE_W-1:0]            in_mode,
  input  logic [acs_pkg::HASH_W-1:0]            in_hash_value,
  input  logic [acs_pkg::BIDX_W-1:0]            in_bucket_index,
  input  logic [acs_pkg::RANK_W-1:0]            in_merge_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_modified,
  output logic [acs_pkg::SUM_W-1:0]             out_rank_sum,
  output logic [acs_pkg::EMPTY_W-1:0]           out_empty_buckets,
  input  logic                                  cfg_we,
  input  logic [acs_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [acs_pkg::KBITS_W-1:0]           cfg_wdata
);

  localparam int AW    = MAX_INDEX_BITS;
  localparam int DEPTH = 1 << MAX_INDEX_BITS;
  localparam int MW    = 21;
  localparam logic [acs_pkg::KBITS_W-1:0] KMAX = acs_pkg::KBITS_W'(MAX_INDEX_BITS);

  // operation codes carried into the update stage
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_RAISE = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // configuration
  logic [acs_pkg::KBITS_W-1:0] index_bits_r;
  logic                        hash_width_sel_r;

  // counters
  logic [acs_pkg::SUM_W-1:0]   rank_total_r, rank_total_nxt;
  logic [acs_pkg::EMPTY_W-1:0] empty_count_r, empty_count_nxt;

  // clear walk
  logic          clr_active_r;
  logic          clr_walked_r;
  logic [AW-1:0] clr_ptr_r;

  // update stage
  logic               s1_v_r;
  logic [1:0]         s1_kind_r;
  logic [AW-1:0]      s1_addr_r;
  acs_pkg::rank_t     s1_rank_r;
  acs_pkg::rank_t     rd_data_r;
  logic               fwd_r;
  acs_pkg::rank_t     fwd_data_r;

  // output word
  logic out_valid_r;
  logic out_modified_r;

  // bucket memory
  acs_pkg::rank_t bucket_mem [DEPTH];

  // front end signals
  logic [acs_pkg::KBITS_W-1:0] k_eff;
  acs_pkg::rank_t              hl;
  acs_pkg::rank_t              w;
  logic [acs_pkg::HASH_W-1:0]  x;
  logic [acs_pkg::HASH_W-1:0]  shifted;
  acs_pkg::rank_t              tz;
  acs_pkg::rank_t              offer_rank;
  acs_pkg::rank_t              merge_rank;
  logic [MW-1:0]               limit;
  logic                        merge_ok;
  logic [acs_pkg::HASH_W-1:0]  merge_wide;
  logic [1:0]                  in_kind;
  logic [AW-1:0]               in_addr;
  acs_pkg::rank_t              in_rank;
  logic [acs_pkg::EMPTY_W-1:0] m_clear;

  // handshake and update signals
  logic           out_free;
  logic           s1_go;
  logic           s1_adv;
  logic           accept;
  acs_pkg::rank_t cur;
  logic           grow;
  acs_pkg::rank_t diff;
  logic [acs_pkg::SUM_W:0] sum_wide;
  logic           mem_we;
  logic [AW-1:0]  mem_wa;
  acs_pkg::rank_t mem_wd;

  // effective index bits, clamped to the supported range
  always_comb begin
    if (index_bits_r == '0) begin
      k_eff = 5'd1;
    end else if (index_bits_r > KMAX) begin
      k_eff = KMAX;
    end else begin
      k_eff = index_bits_r;
    end
  end

  // offer: bucket from the top bits, rank from the trailing zeros
  assign hl         = hash_width_sel_r ? acs_pkg::HL_64 : acs_pkg::HL_32;
  assign w          = hl - acs_pkg::RANK_W'(k_eff);
  assign x          = hash_width_sel_r ? in_hash_value : {32'b0, in_hash_value[31:0]};
  assign shifted    = x >> w;
  assign tz         = acs_pkg::trail_zeros(x);
  assign offer_rank = ((tz < w) ? tz : w) + 7'd1;

  // merge: range check and value cap
  assign limit      = MW'(1) << k_eff;
  assign merge_ok   = MW'(in_bucket_index) < limit;
  assign merge_wide = acs_pkg::HASH_W'(in_bucket_index);
  assign merge_rank = (in_merge_value > acs_pkg::MERGE_CAP) ? acs_pkg::MERGE_CAP
                                                             : in_merge_value;

  // bucket count after a clear, saturated to the counter width
  assign m_clear = (limit > MW'(acs_pkg::EMPTY_MAX)) ? acs_pkg::EMPTY_MAX
                                                      : limit[acs_pkg::EMPTY_W-1:0];

  // decode the incoming word
  always_comb begin
    in_kind = OP_NONE;
    in_addr = merge_wide[AW-1:0];
    in_rank = merge_rank;
    unique case (in_mode)
      acs_pkg::MODE_OFFER: begin
        in_kind = OP_RAISE;
        in_addr = shifted[AW-1:0];
        in_rank = offer_rank;
      end
      acs_pkg::MODE_MERGE: begin
        in_kind = merge_ok ? OP_RAISE : OP_NONE;
      end
      acs_pkg::MODE_CLEAR: begin
        in_kind = OP_CLEAR;
      end
      default: begin
        in_kind = OP_NONE;
      end
    endcase
  end

  // handshake
  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = out_free && !clr_active_r && ((s1_kind_r != OP_CLEAR) || clr_walked_r);
  assign s1_adv   = s1_v_r && s1_go;
  assign in_stall = clr_active_r || (s1_v_r && !s1_go);
  assign accept   = in_valid && !in_stall;

  // read-modify-write of the bucket
  assign cur  = fwd_r ? fwd_data_r : rd_data_r;
  assign grow = (s1_kind_r == OP_RAISE) && (cur < s1_rank_r);
  assign diff = s1_rank_r - cur;
  assign sum_wide = {1'b0, rank_total_r} + (acs_pkg::SUM_W + 1)'(diff);

  // memory write port: clear walk or bucket raise
  assign mem_we = clr_active_r || (s1_adv && grow);
  assign mem_wa = clr_active_r ? clr_ptr_r : s1_addr_r;
  assign mem_wd = clr_active_r ? '0 : s1_rank_r;

  // counter next values
  always_comb begin
    rank_total_nxt  = rank_total_r;
    empty_count_nxt = empty_count_r;
    if (s1_adv) begin
      if (s1_kind_r == OP_CLEAR) begin
        rank_total_nxt  = '0;
        empty_count_nxt = m_clear;
      end else if (grow) begin
        rank_total_nxt = (sum_wide > (acs_pkg::SUM_W + 1)'(acs_pkg::RANK_MAX))
                         ? acs_pkg::RANK_MAX : sum_wide[acs_pkg::SUM_W-1:0];
        if ((cur == '0) && (empty_count_r != '0)) begin
          empty_count_nxt = empty_count_r - 17'd1;
        end
      end
    end
  end

  // bucket memory, read data registered
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bucket_mem[mem_wa] <= mem_wd;
    end
    if (accept) begin
      rd_data_r <= bucket_mem[in_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_bits_r     <= acs_pkg::KBITS_RESET;
      hash_width_sel_r <= 1'b1;
      rank_total_r     <= '0;
      empty_count_r    <= acs_pkg::EMPTY_RESET;
      clr_active_r     <= 1'b1;
      clr_walked_r     <= 1'b0;
      clr_ptr_r        <= '0;
      s1_v_r           <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          acs_pkg::REG_INDEX_BITS: index_bits_r     <= cfg_wdata;
          acs_pkg::REG_HASH_WIDTH: hash_width_sel_r <= cfg_wdata[0];
          default: ;
        endcase
      end

      rank_total_r  <= rank_total_nxt;
      empty_count_r <= empty_count_nxt;

      // clear walk: start when a clear word waits, stop after the last bucket
      if (clr_active_r) begin
        clr_ptr_r <= clr_ptr_r + AW'(1);
        if (clr_ptr_r == '1) begin
          clr_active_r <= 1'b0;
          clr_walked_r <= s1_v_r;
        end
      end else if (s1_v_r && (s1_kind_r == OP_CLEAR) && !clr_walked_r) begin
        clr_active_r <= 1'b1;
      end else if (s1_adv) begin
        clr_walked_r <= 1'b0;
      end

      // update stage occupancy
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end

      // output word
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // stage payload and forwarding
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind_r  <= in_kind;
      s1_addr_r  <= in_addr;
      s1_rank_r  <= in_rank;
      fwd_r      <= mem_we && (mem_wa == in_addr);
      fwd_data_r <= mem_wd;
    end
    if (s1_adv) begin
      out_modified_r <= grow;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_modified      = out_modified_r;
  assign out_rank_sum      = rank_total_r;
  assign out_empty_buckets = empty_count_r;

`ifndef ASSERT_OFF
  // no word enters while the memory is being cleared
  a_no_accept_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !accept)
    else $error("word accepted during clear walk");

  // the walk ends after the last bucket
  a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (clr_active_r && (clr_ptr_r == '1)) |=> !clr_active_r)
    else $error("clear walk did not stop");

  // a finished clear leaves the rank sum at zero
  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (s1_kind_r == OP_CLEAR)) |=> (rank_total_r == '0))
    else $error("rank sum not zero after clear");

  // a grown bucket leaves a nonzero rank sum
  a_grow_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_modified_r) |-> (out_rank_sum != '0))
    else $error("bucket grew but rank sum is zero");
`endif

endmodule
